// ===== rtl/bmplme_pkg.sv =====
// ----------------------------------------------------------------------------
// bmplme_pkg
// Types and constants shared by the BMP LSB message extractor modules.
// ----------------------------------------------------------------------------
package bmplme_pkg;

  // Extraction phase of the file walker.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SKIP    = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  // Result status codes carried on the result tuser.
  typedef enum logic [2:0] {
    ST_DATA      = 3'd0,
    ST_NOT_BMP   = 3'd1,
    ST_NOT_24BIT = 3'd2,
    ST_NO_MSG    = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_BAD_OFS   = 3'd5
  } status_t;

  // Header layout.
  localparam logic [31:0] HDR_LEN   = 32'd54;
  localparam logic [31:0] HDR_LAST  = 32'd53;
  localparam logic [31:0] POS_SIG0  = 32'd0;
  localparam logic [31:0] POS_SIG1  = 32'd1;
  localparam logic [31:0] POS_OFS0  = 32'd10;
  localparam logic [31:0] POS_OFS1  = 32'd11;
  localparam logic [31:0] POS_OFS2  = 32'd12;
  localparam logic [31:0] POS_OFS3  = 32'd13;
  localparam logic [31:0] POS_BPP0  = 32'd28;
  localparam logic [31:0] POS_BPP1  = 32'd29;
  localparam logic [7:0]  SIG_B     = 8'h42;
  localparam logic [7:0]  SIG_M     = 8'h4D;
  localparam logic [15:0] DEPTH_24  = 16'd24;

  // Bit counts that close the length field and a message byte.
  localparam logic [4:0]  LEN_BITS_LAST  = 5'd31;
  localparam logic [4:0]  BYTE_BITS_LAST = 5'd7;

  // One file byte as held in the input register.
  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [7:0] message_byte;
    logic       last_of_message;
    status_t    status;
  } result_t;

endpackage

// ===== rtl/bmplme_in_stage.sv =====
// ----------------------------------------------------------------------------
// bmplme_in_stage
// Input register: holds one file byte until the core consumes it.
// ----------------------------------------------------------------------------
module bmplme_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] file_byte
  input  logic               in_tlast,   // end_of_file
  input  logic               take_i,
  output logic               item_valid_o,
  output bmplme_pkg::item_t  item_o
);
  import bmplme_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // A new word may enter when the register is empty or is being emptied.
  assign in_tready = !valid_r || take_i;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.file_byte   <= in_tdata;
      item_r.end_of_file <= in_tlast;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

// ===== rtl/bmplme_core.sv =====
// ----------------------------------------------------------------------------
// bmplme_core
// Header check, offset skip and LSB gathering for one file byte per cycle while fire_i is high.
// ----------------------------------------------------------------------------
module bmplme_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire_i,
  input  bmplme_pkg::item_t    item_i,
  output logic                 res_valid_o,
  output bmplme_pkg::result_t  res_o
);
  import bmplme_pkg::*;

  phase_t      phase_r,    phase_nxt;
  logic [31:0] byte_pos_r, byte_pos_nxt;
  logic [31:0] pix_ofs_r,  pix_ofs_nxt;
  logic [15:0] depth_r,    depth_nxt;
  logic        sig_ok_r,   sig_ok_nxt;
  logic [31:0] gather_r,   gather_nxt;
  logic [4:0]  bit_cnt_r,  bit_cnt_nxt;
  logic [31:0] left_r,     left_nxt;

  logic [7:0]  b;
  logic        eof;
  logic [31:0] shifted;
  logic        err;
  status_t     err_code;
  logic        data_vld;
  logic        data_last;

  assign b       = item_i.file_byte;
  assign eof     = item_i.end_of_file;
  assign shifted = {gather_r[30:0], b[0]};

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_nxt    = phase_r;
    byte_pos_nxt = byte_pos_r;
    pix_ofs_nxt  = pix_ofs_r;
    depth_nxt    = depth_r;
    sig_ok_nxt   = sig_ok_r;
    gather_nxt   = gather_r;
    bit_cnt_nxt  = bit_cnt_r;
    left_nxt     = left_r;
    err          = 1'b0;
    err_code     = ST_DATA;
    data_vld     = 1'b0;
    data_last    = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (byte_pos_r == POS_SIG0 && b != SIG_B) sig_ok_nxt = 1'b0;
        if (byte_pos_r == POS_SIG1 && b != SIG_M) sig_ok_nxt = 1'b0;
        if (byte_pos_r == POS_OFS0) pix_ofs_nxt[7:0]   = pix_ofs_r[7:0]   | b;
        if (byte_pos_r == POS_OFS1) pix_ofs_nxt[15:8]  = pix_ofs_r[15:8]  | b;
        if (byte_pos_r == POS_OFS2) pix_ofs_nxt[23:16] = pix_ofs_r[23:16] | b;
        if (byte_pos_r == POS_OFS3) pix_ofs_nxt[31:24] = pix_ofs_r[31:24] | b;
        if (byte_pos_r == POS_BPP0) depth_nxt[7:0]  = b;
        if (byte_pos_r == POS_BPP1) depth_nxt[15:8] = b;
        // The last header byte never touches the checked fields.
        if (byte_pos_r >= HDR_LAST) begin
          byte_pos_nxt = HDR_LEN;
          priority if (!sig_ok_r) begin
            err = 1'b1; err_code = ST_NOT_BMP;
          end else if (depth_r != DEPTH_24) begin
            err = 1'b1; err_code = ST_NOT_24BIT;
          end else if (pix_ofs_r < HDR_LEN) begin
            err = 1'b1; err_code = ST_BAD_OFS;
          end else begin
            phase_nxt = (pix_ofs_r == HDR_LEN) ? PH_LENGTH : PH_SKIP;
            if (eof) begin
              err = 1'b1; err_code = ST_NO_MSG;
            end
          end
        end else begin
          byte_pos_nxt = byte_pos_r + 32'd1;
          if (eof) begin
            err = 1'b1; err_code = ST_NOT_BMP;
          end
        end
      end
      PH_SKIP: begin
        if (byte_pos_r + 32'd1 >= pix_ofs_r) phase_nxt = PH_LENGTH;
        byte_pos_nxt = byte_pos_r + 32'd1;
        if (eof) begin
          err = 1'b1; err_code = ST_NO_MSG;
        end
      end
      PH_LENGTH: begin
        gather_nxt = shifted;
        if (bit_cnt_r == LEN_BITS_LAST) begin
          gather_nxt  = '0;
          bit_cnt_nxt = '0;
          if (shifted == 32'd0) begin
            err = 1'b1; err_code = ST_NO_MSG;
          end else begin
            left_nxt  = shifted;
            phase_nxt = PH_PAYLOAD;
            if (eof) begin
              err = 1'b1; err_code = ST_TRUNC;
            end
          end
        end else begin
          bit_cnt_nxt = bit_cnt_r + 5'd1;
          if (eof) begin
            err = 1'b1; err_code = ST_NO_MSG;
          end
        end
      end
      PH_PAYLOAD: begin
        gather_nxt = {24'd0, shifted[7:0]};
        if (bit_cnt_r == BYTE_BITS_LAST) begin
          gather_nxt  = '0;
          bit_cnt_nxt = '0;
          if (left_r <= 32'd1) begin
            left_nxt  = '0;
            phase_nxt = PH_DONE;
            data_vld  = 1'b1;
            data_last = 1'b1;
          end else begin
            left_nxt = left_r - 32'd1;
            if (eof) begin
              err = 1'b1; err_code = ST_TRUNC;
            end else begin
              data_vld = 1'b1;
            end
          end
        end else begin
          bit_cnt_nxt = bit_cnt_r + 5'd1;
          if (eof) begin
            err = 1'b1; err_code = ST_TRUNC;
          end
        end
      end
      default: begin
      end
    endcase

    if (err) phase_nxt = PH_DONE;

    // End of file returns everything to the reset state.
    if (eof) begin
      phase_nxt    = PH_HEADER;
      byte_pos_nxt = '0;
      pix_ofs_nxt  = '0;
      depth_nxt    = '0;
      sig_ok_nxt   = 1'b1;
      gather_nxt   = '0;
      bit_cnt_nxt  = '0;
      left_nxt     = '0;
    end
  end

  // Result word: an error replaces any data byte.
  always_comb begin
    res_valid_o = err || data_vld;
    if (err) begin
      res_o.message_byte    = '0;
      res_o.last_of_message = 1'b1;
      res_o.status          = err_code;
    end else begin
      res_o.message_byte    = shifted[7:0];
      res_o.last_of_message = data_last;
      res_o.status          = ST_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      byte_pos_r <= '0;
      pix_ofs_r  <= '0;
      depth_r    <= '0;
      sig_ok_r   <= 1'b1;
      gather_r   <= '0;
      bit_cnt_r  <= '0;
      left_r     <= '0;
    end else if (fire_i) begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      pix_ofs_r  <= pix_ofs_nxt;
      depth_r    <= depth_nxt;
      sig_ok_r   <= sig_ok_nxt;
      gather_r   <= gather_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      left_r     <= left_nxt;
    end
  end

endmodule

// ===== rtl/bmplme_out_stage.sv =====
// ----------------------------------------------------------------------------
// bmplme_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module bmplme_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  bmplme_pkg::result_t  res_i,
  output logic                 ready_o,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [7:0] message_byte
  output logic                 out_tlast,  // last_of_message
  output logic [2:0]           out_tuser   // [2:0] status
);
  import bmplme_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // The register can take a word when empty or when its word leaves now.
  assign ready_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.message_byte;
  assign out_tlast  = res_r.last_of_message;
  assign out_tuser  = res_r.status;

endmodule

// ===== rtl/bmp_lsb_message_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// bmp_lsb_message_extractor_unit
// Extracts an LSB-hidden message from a 24-bit BMP file streamed byte-wise.
// ----------------------------------------------------------------------------
// The input stream carries one file byte per word on in_tdata, with in_tlast
// marking the final byte of the file. The 54-byte header is checked for the
// 'BM' signature and a depth of 24 bits, the pixel offset is latched, bytes
// up to that offset are skipped, and then the LSBs of later bytes build a
// 32-bit length followed by message bytes, most significant bit first.
// Each message byte leaves on out_tdata with status 0 on out_tuser; the
// final one has out_tlast set. An error gives one word with data zero,
// out_tlast set and its code on out_tuser; bytes are then ignored until
// the end of the file, after which the block starts afresh.
// One file byte is accepted every cycle while the result register is not held
// by a stalled receiver. An accepted byte is held in the input register and
// any result it gives is written to the output register once that register can
// take it. The rate is set by the state update in the core. Reset returns the
// walker to the header phase and empties both registers. When the receiver
// stalls with a word held, in_tready drops once the input register is full.
// ----------------------------------------------------------------------------
module bmp_lsb_message_extractor_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] file_byte
  input  logic       in_tlast,   // end_of_file
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] message_byte
  output logic       out_tlast,  // last_of_message
  output logic [2:0] out_tuser   // [2:0] status
);
  import bmplme_pkg::*;

  item_t   item;
  logic    item_valid;
  logic    out_ready;
  logic    fire;
  logic    res_valid;
  result_t res;

  // A byte is processed when it is held and the result register can take it.
  assign fire = item_valid && out_ready;

  bmplme_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .take_i       (fire),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  bmplme_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bmplme_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (fire && res_valid),
    .res_i      (res),
    .ready_o    (out_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
